[rtl/core/rmth_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmth_pkg
// Shared types, sizes and helpers for the two-heap running median block.
// ----------------------------------------------------------------------------
package rmth_pkg;

  localparam int CAPACITY   = 1024;
  localparam int HEAP_DEPTH = CAPACITY / 2;
  localparam int ADDR_W     = $clog2(HEAP_DEPTH);
  localparam int CNT_W      = $clog2(HEAP_DEPTH + 1);
  localparam int SUM_W      = CNT_W + 1;
  localparam int KID_W      = ADDR_W + 2;
  localparam int DATA_W     = 32;
  localparam int STORED_W   = 11;

  // command to one heap unit
  typedef struct packed {
    logic                     go;
    logic                     replace;  // 1: replace top and sift down, 0: push
    logic signed [DATA_W-1:0] value;
  } heap_cmd_t;

  typedef enum logic [2:0] {
    H_IDLE,
    H_UP_RD,
    H_UP_CMP,
    H_DN_RD,
    H_DN_CMP
  } heap_state_t;

  typedef enum logic [1:0] {
    C_IDLE,
    C_RUN,
    C_RES
  } ctrl_state_t;

  // true if a belongs above b in the heap
  function automatic logic heap_above(logic signed [DATA_W-1:0] a,
                                      logic signed [DATA_W-1:0] b,
                                      logic is_max);
    heap_above = is_max ? (a > b) : (a < b);
  endfunction

endpackage

[rtl/core/rmth_heap.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmth_heap
// One binary heap in a synchronous RAM. Push sifts up, replace-top sifts
// down (hole method): one write per level, one read up, two reads down.
// ----------------------------------------------------------------------------
module rmth_heap (
  input  logic                            clk,
  input  logic                            rst,
  input  rmth_pkg::heap_cmd_t             cmd,
  input  logic [rmth_pkg::CNT_W-1:0]      cnt,
  input  logic                            max_mode,
  output logic                            done,
  output logic signed [rmth_pkg::DATA_W-1:0] top
);
  import rmth_pkg::*;

  heap_state_t state, state_next;

  logic [ADDR_W-1:0]        idx, idx_next;
  logic signed [DATA_W-1:0] val, val_next;

  logic signed [DATA_W-1:0] mem [HEAP_DEPTH];
  logic signed [DATA_W-1:0] rd_l, rd_r;
  logic [ADDR_W-1:0]        ra_l, ra_r;
  logic                     we;
  logic [ADDR_W-1:0]        waddr;
  logic signed [DATA_W-1:0] wdata;

  logic [KID_W-1:0]         kid_l, kid_r;
  logic                     l_ok, r_ok;
  logic [ADDR_W-1:0]        parent;
  logic signed [DATA_W-1:0] best_val;
  logic [1:0]               best_sel;

  // child and parent indexes of the hole
  assign kid_l  = {1'b0, idx, 1'b1};
  assign kid_r  = kid_l + KID_W'(1);
  assign l_ok   = kid_l < KID_W'(cnt);
  assign r_ok   = kid_r < KID_W'(cnt);
  assign parent = (idx - ADDR_W'(1)) >> 1;

  // pick the best of hole value and both children
  always_comb begin
    best_val = val;
    best_sel = 2'd0;
    if (l_ok && heap_above(rd_l, best_val, max_mode)) begin
      best_val = rd_l;
      best_sel = 2'd1;
    end
    if (r_ok && heap_above(rd_r, best_val, max_mode)) begin
      best_val = rd_r;
      best_sel = 2'd2;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      H_IDLE:   if (cmd.go) state_next = cmd.replace ? H_DN_RD : H_UP_RD;
      H_UP_RD:  state_next = (idx == '0) ? H_IDLE : H_UP_CMP;
      H_UP_CMP: state_next = heap_above(val, rd_l, max_mode) ? H_UP_RD : H_IDLE;
      H_DN_RD:  state_next = l_ok ? H_DN_CMP : H_IDLE;
      H_DN_CMP: state_next = (best_sel == 2'd0) ? H_IDLE : H_DN_RD;
      default:  state_next = H_IDLE;
    endcase
  end

  // datapath and memory port control
  always_comb begin
    idx_next = idx;
    val_next = val;
    we       = 1'b0;
    waddr    = idx;
    wdata    = val;
    ra_l     = parent;
    ra_r     = parent;
    done     = 1'b0;
    unique case (state)
      H_IDLE: begin
        if (cmd.go) begin
          val_next = cmd.value;
          idx_next = cmd.replace ? '0 : cnt[ADDR_W-1:0];
        end
      end
      H_UP_RD: begin
        if (idx == '0) begin
          we   = 1'b1;
          done = 1'b1;
        end
      end
      H_UP_CMP: begin
        we = 1'b1;
        if (heap_above(val, rd_l, max_mode)) begin
          wdata    = rd_l;
          idx_next = parent;
        end else begin
          done = 1'b1;
        end
      end
      H_DN_RD: begin
        ra_l = kid_l[ADDR_W-1:0];
        ra_r = kid_r[ADDR_W-1:0];
        if (!l_ok) begin
          we   = 1'b1;
          done = 1'b1;
        end
      end
      H_DN_CMP: begin
        we = 1'b1;
        if (best_sel == 2'd0) begin
          done = 1'b1;
        end else begin
          wdata    = best_val;
          idx_next = (best_sel == 2'd1) ? kid_l[ADDR_W-1:0] : kid_r[ADDR_W-1:0];
        end
      end
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= H_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // hole index and value in flight
  always_ff @(posedge clk) begin
    idx <= idx_next;
    val <= val_next;
  end

  // heap RAM, two registered read ports
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_l <= mem[ra_l];
    rd_r <= mem[ra_r];
  end

  // cached root
  always_ff @(posedge clk) begin
    if (we && waddr == '0) begin
      top <= wdata;
    end
  end

`ifndef SYNTHESIS
  a_go_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.go |-> state == H_IDLE)
    else $error("heap command while busy");
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> state != H_IDLE)
    else $error("heap done while idle");
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    (cmd.go && !cmd.replace) |-> cnt < CNT_W'(HEAP_DEPTH))
    else $error("push into full heap");
  a_replace_nonempty: assert property (@(posedge clk) disable iff (rst)
    (cmd.go && cmd.replace) |-> cnt != '0)
    else $error("replace on empty heap");
`endif

endmodule

[rtl/core/running_median_two_heaps.sv]
`timescale 1ns / 1ps
// Each heap level moved costs a read state and a compare state in the heap
// units. Throughput: one transaction at a time; the next input is accepted in
// the cycle after the result register loads. The two heap RAMs sift in
// parallel, each heap being 9 levels deep.
// A full store skips the heaps and answers with the overflow flag.
// Reset empties both heaps and clears the last median; RAM contents are kept.
// ----------------------------------------------------------------------------
// running_median_two_heaps
// Lower median of a stream, kept in a max-heap (lower half) and a min-heap
// (upper half), each in its own RAM.
// ----------------------------------------------------------------------------
module running_median_two_heaps (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                start_req,
  input  logic signed [rmth_pkg::DATA_W-1:0]  sample,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [rmth_pkg::DATA_W-1:0]  median,
  output logic [rmth_pkg::STORED_W-1:0]       stored,
  output logic                                overflow
);
  import rmth_pkg::*;

  ctrl_state_t state, state_next;

  logic [CNT_W-1:0]         lc, uc;
  logic [CNT_W-1:0]         eff_lc, eff_uc;
  logic [CNT_W-1:0]         new_lc, new_uc;
  logic signed [DATA_W-1:0] last_median;
  logic                     ovf, ovf_next;
  logic                     grow_upper, grow_upper_next;
  logic                     pend_l, pend_u;
  logic                     full;
  logic                     accept, emit;
  heap_cmd_t                cmd_l, cmd_u, cmd_l_next, cmd_u_next;
  logic                     done_l, done_u;
  logic signed [DATA_W-1:0] ltop, utop, med_next;

  assign accept   = in_valid && in_ready;
  assign emit     = (state == C_RES) && (!out_valid || out_ready);
  assign in_ready = (state == C_IDLE);

  // counts after an optional start request
  assign eff_lc = start_req ? '0 : lc;
  assign eff_uc = start_req ? '0 : uc;
  assign full   = (SUM_W'(eff_lc) + SUM_W'(eff_uc)) >= SUM_W'(CAPACITY);

  // decide which heap gets what
  always_comb begin
    cmd_l_next      = '{go: 1'b0, replace: 1'b0, value: sample};
    cmd_u_next      = '{go: 1'b0, replace: 1'b0, value: sample};
    ovf_next        = 1'b0;
    grow_upper_next = 1'b0;
    if (full) begin
      ovf_next = 1'b1;
    end else if (eff_uc == eff_lc) begin
      grow_upper_next = 1'b1;
      cmd_u_next.go   = 1'b1;
      if (eff_lc != '0 && sample < ltop) begin
        cmd_l_next       = '{go: 1'b1, replace: 1'b1, value: sample};
        cmd_u_next.value = ltop;
      end
    end else begin
      cmd_l_next.go = 1'b1;
      if (!(sample < utop)) begin
        cmd_u_next       = '{go: 1'b1, replace: 1'b1, value: sample};
        cmd_l_next.value = utop;
      end
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      C_IDLE:  if (accept) state_next = full ? C_RES : C_RUN;
      C_RUN:   if (!pend_l && !pend_u) state_next = C_RES;
      C_RES:   if (emit) state_next = C_IDLE;
      default: state_next = C_IDLE;
    endcase
  end

  // result of this transaction
  always_comb begin
    new_lc   = lc + CNT_W'(!ovf && !grow_upper);
    new_uc   = uc + CNT_W'(!ovf && grow_upper);
    med_next = ovf ? last_median : ((new_uc == new_lc) ? ltop : utop);
  end

  // control registers and heap commands
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= C_IDLE;
      lc          <= '0;
      uc          <= '0;
      last_median <= '0;
      out_valid   <= 1'b0;
      pend_l      <= 1'b0;
      pend_u      <= 1'b0;
      cmd_l.go    <= 1'b0;
      cmd_u.go    <= 1'b0;
    end else begin
      state    <= state_next;
      cmd_l.go <= accept && cmd_l_next.go;
      cmd_u.go <= accept && cmd_u_next.go;
      if (accept) begin
        lc            <= eff_lc;
        uc            <= eff_uc;
        pend_l        <= cmd_l_next.go;
        pend_u        <= cmd_u_next.go;
        cmd_l.replace <= cmd_l_next.replace;
        cmd_l.value   <= cmd_l_next.value;
        cmd_u.replace <= cmd_u_next.replace;
        cmd_u.value   <= cmd_u_next.value;
      end else begin
        if (done_l) pend_l <= 1'b0;
        if (done_u) pend_u <= 1'b0;
      end
      if (emit) begin
        lc          <= new_lc;
        uc          <= new_uc;
        last_median <= med_next;
        out_valid   <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      ovf        <= ovf_next;
      grow_upper <= grow_upper_next;
    end
    if (emit) begin
      median   <= med_next;
      stored   <= STORED_W'(SUM_W'(new_lc) + SUM_W'(new_uc));
      overflow <= ovf;
    end
  end

  // lower half: max-heap
  rmth_heap u_lower (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd_l),
    .cnt      (lc),
    .max_mode (1'b1),
    .done     (done_l),
    .top      (ltop)
  );

  // upper half: min-heap
  rmth_heap u_upper (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd_u),
    .cnt      (uc),
    .max_mode (1'b0),
    .done     (done_u),
    .top      (utop)
  );

`ifndef SYNTHESIS
  a_balance: assert property (@(posedge clk) disable iff (rst)
    (lc == uc) || (uc == lc + CNT_W'(1)))
    else $error("heap counts out of balance");
  a_ovf_full: assert property (@(posedge clk) disable iff (rst)
    (state == C_RES && ovf) |-> (SUM_W'(lc) + SUM_W'(uc)) == SUM_W'(CAPACITY))
    else $error("overflow without full store");
  a_done_pend: assert property (@(posedge clk) disable iff (rst)
    (done_l |-> pend_l) and (done_u |-> pend_u))
    else $error("heap done without pending command");
`endif

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the two-heap running median. A sorted-list model
// of the stored values predicts median, count and overflow for each sample.
// ----------------------------------------------------------------------------
module tb_top;
  import rmth_pkg::*;

  localparam int LIMIT_CYCLES = 1500000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic start_req = 1'b0;
  logic signed [DATA_W-1:0] sample = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [DATA_W-1:0] median;
  logic [STORED_W-1:0] stored;
  logic overflow;

  // expected result of one sample
  typedef struct packed {
    logic signed [DATA_W-1:0] med;
    logic [STORED_W-1:0]      cnt;
    logic                     ovf;
  } median_res_t;

  median_res_t exp_results[$];
  logic signed [DATA_W-1:0] held_vals[$];  // kept sorted ascending
  logic signed [DATA_W-1:0] prev_median = '0;
  int err_count = 0;
  int cycle_count = 0;
  bit hold_off = 1'b0;
  bit no_gaps = 1'b0;

  running_median_two_heaps u_top (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run-time limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("[running_median_two_heaps] ERROR");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want,
             cycle_count);
    err_count++;
  endtask

  // lower median predictor: insert into sorted list, pick ceil(n/2)-th
  function automatic median_res_t predict_median(logic st,
                                                 logic signed [DATA_W-1:0] v);
    median_res_t r;
    int pos;
    if (st) held_vals.delete();
    r.ovf = 1'b0;
    if (held_vals.size() >= CAPACITY) begin
      r.ovf = 1'b1;
    end else begin
      pos = held_vals.size();
      for (int i = 0; i < held_vals.size(); i++)
        if (held_vals[i] > v) begin
          pos = i;
          break;
        end
      held_vals.insert(pos, v);
      prev_median = held_vals[(held_vals.size() + 1) / 2 - 1];
    end
    r.med = prev_median;
    r.cnt = STORED_W'(held_vals.size());
    return r;
  endfunction

  // send one transaction, with an optional random gap before it;
  // valid stays up after acceptance unless the next call idles or the run ends
  task automatic send_sample(input logic st, input logic signed [DATA_W-1:0] v);
    int gap;
    gap = no_gaps ? 0 : (($urandom_range(0, 9) == 0) ? $urandom_range(5, 40)
                                                      : $urandom_range(0, 2));
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    start_req <= st;
    sample    <= v;
    exp_results.insert(exp_results.size(), predict_median(st, v));
    do @(posedge clk); while (!in_ready);
  endtask

  // receiver readiness
  always @(posedge clk) begin
    if (rst || hold_off) out_ready <= 1'b0;
    else if (no_gaps) out_ready <= 1'b1;
    else out_ready <= ($urandom_range(0, 19) == 0) ? 1'b0 : ($urandom_range(0, 3) != 0);
  end

  // result checker
  always @(posedge clk) begin
    median_res_t e;
    if (!rst && out_valid && out_ready) begin
      if (exp_results.size() == 0) begin
        report_mismatch("unexpected", 64'({median, stored}), 64'd0);
      end else begin
        e = exp_results.pop_front();
        if (median !== e.med) report_mismatch("median", 64'(median), 64'(e.med));
        if (stored !== e.cnt) report_mismatch("stored", 64'(stored), 64'(e.cnt));
        if (overflow !== e.ovf)
          report_mismatch("overflow", 64'(overflow), 64'(e.ovf));
      end
    end
  end

  function automatic logic signed [DATA_W-1:0] rand_val(int mode);
    case (mode)
      0: return $urandom_range(0, 20) - 10;
      1: return DATA_W'({$urandom, $urandom} >> 1);
      default: return $urandom;
    endcase
  endfunction

  task automatic test_extremes();
    send_sample(1'b0, 32'sh7fffffff);
    send_sample(1'b0, 32'sh80000000);
    send_sample(1'b0, 32'sh0);
    send_sample(1'b0, -32'sd1);
    send_sample(1'b0, 32'sh7fffffff);
    send_sample(1'b0, 32'sh80000000);
    send_sample(1'b0, 32'sh55555555);
    send_sample(1'b0, 32'shaaaaaaaa);
    send_sample(1'b1, 32'sd5);
    send_sample(1'b0, 32'sd5);
    send_sample(1'b0, 32'sd3);
    send_sample(1'b0, 32'sd9);
    send_sample(1'b1, 32'sh80000000);
  endtask

  // fill to capacity, then push past it; a start recovers
  task automatic test_overflow();
    send_sample(1'b1, rand_val(2));
    for (int i = 1; i < CAPACITY + 4; i++) send_sample(1'b0, rand_val(i % 3));
    send_sample(1'b1, 32'sd7);
  endtask

  // receiver stalls long while samples keep coming
  task automatic test_backpressure();
    fork
      begin
        hold_off = 1'b1;
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 6; i++) send_sample(1'b0, rand_val(2));
    join
  endtask

  task automatic test_random_streams();
    for (int i = 0; i < 60; i++) begin
      no_gaps = (i % 10) == 3;
      send_sample($urandom_range(0, 14) == 0, rand_val($urandom_range(0, 2)));
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_extremes();
    test_backpressure();
    test_overflow();
    test_random_streams();
    in_valid <= 1'b0;
    wait (exp_results.size() == 0);
    repeat (50) @(posedge clk);
    if (err_count == 0) $display("[running_median_two_heaps] OK");
    else $display("[running_median_two_heaps] ERROR");
    $finish;
  end
endmodule
